@@ design/voxel_line_rasterizer_macros.svh @@
// Assertion macros used by vlr_back, the voxel line rasterizer back end.
// Depends on a clock named clk and a reset named rst in the module that uses them.
`ifndef VOXEL_LINE_RASTERIZER_MACROS_SVH
`define VOXEL_LINE_RASTERIZER_MACROS_SVH
`ifndef SYNTHESIS
`define VLR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("voxel line rasterizer check failed");
`define VLR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("voxel line rasterizer check failed");
`else
`define VLR_ASSERT_SAME(lbl, ante, cons)
`define VLR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ design/vlr_pkg.sv @@
// Shared types and constants of the voxel line rasterizer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package vlr_pkg;

  localparam int COORD_W      = 3;
  localparam int COLOR_W      = 8;
  localparam int NUM_AXES     = 3;
  localparam int SIDE_DEFAULT = 8;
  localparam int QUEUE_DEPTH  = 2;

  typedef struct packed {
    logic [COORD_W-1:0] lo;
    logic [COORD_W-1:0] delta;
    logic               rev;
  } axis_t;

  typedef struct packed {
    axis_t [NUM_AXES-1:0] ax;
    logic [COORD_W-1:0]   cnt;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   blue;
  } line_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } back_state_t;

endpackage

`default_nettype wire

@@ design/vlr_front.sv @@
// Front end: takes a line request, clamps the endpoints to the grid and
// works out per-axis low point, delta, direction and the step count. Uses vlr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vlr_front import vlr_pkg::*; #(
  parameter int SIDE = SIDE_DEFAULT
) (
  input  logic               start,
  input  logic               busy,
  input  logic [COORD_W-1:0] start_x,
  input  logic [COORD_W-1:0] start_y,
  input  logic [COORD_W-1:0] start_z,
  input  logic [COORD_W-1:0] end_x,
  input  logic [COORD_W-1:0] end_y,
  input  logic [COORD_W-1:0] end_z,
  input  logic [COLOR_W-1:0] color_red,
  input  logic [COLOR_W-1:0] color_green,
  input  logic [COLOR_W-1:0] color_blue,
  output logic               push,
  output line_t              item
);

  localparam int MAX_C = ((SIDE - 1) > ((1 << COORD_W) - 1)) ? ((1 << COORD_W) - 1) : (SIDE - 1);
  localparam logic [COORD_W-1:0] MAX_COORD = COORD_W'(MAX_C);

  logic [COORD_W-1:0] pa [NUM_AXES];
  logic [COORD_W-1:0] pb [NUM_AXES];
  logic [COORD_W-1:0] cnt01;

  assign push = start && !busy;

  always_comb begin
    pa[0] = (start_x > MAX_COORD) ? MAX_COORD : start_x;
    pa[1] = (start_y > MAX_COORD) ? MAX_COORD : start_y;
    pa[2] = (start_z > MAX_COORD) ? MAX_COORD : start_z;
    pb[0] = (end_x > MAX_COORD) ? MAX_COORD : end_x;
    pb[1] = (end_y > MAX_COORD) ? MAX_COORD : end_y;
    pb[2] = (end_z > MAX_COORD) ? MAX_COORD : end_z;
    for (int a = 0; a < NUM_AXES; a++) begin
      item.ax[a].rev   = pa[a] > pb[a];
      item.ax[a].lo    = item.ax[a].rev ? pb[a] : pa[a];
      item.ax[a].delta = item.ax[a].rev ? (pa[a] - pb[a]) : (pb[a] - pa[a]);
    end
    cnt01 = (item.ax[1].delta > item.ax[0].delta) ? item.ax[1].delta : item.ax[0].delta;
    item.cnt   = (item.ax[2].delta > cnt01) ? item.ax[2].delta : cnt01;
    item.red   = color_red;
    item.green = color_green;
    item.blue  = color_blue;
  end

endmodule

`default_nettype wire

@@ design/vlr_queue.sv @@
// Short request queue between the front end and the stepping back end.
// Uses line_t and QUEUE_DEPTH from vlr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vlr_queue import vlr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  line_t push_item,
  input  logic  pop,
  output line_t head,
  output logic  head_valid,
  output logic  full
);

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(QUEUE_DEPTH);

  line_t              entry [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [FILL_W-1:0]  fill;
  logic               do_push;
  logic               do_pop;

  assign head_valid = fill != '0;
  assign full       = fill == FULL_FILL;
  assign head       = entry[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/vlr_back.sv @@
// Back end: steps one queued line request and emits one voxel per cycle using
// per-axis quotient and remainder registers. Uses vlr_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "voxel_line_rasterizer_macros.svh"

module vlr_back import vlr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  line_t              head,
  input  logic               head_valid,
  output logic               pop,
  output logic               voxel_valid,
  output logic [COORD_W-1:0] voxel_x,
  output logic [COORD_W-1:0] voxel_y,
  output logic [COORD_W-1:0] voxel_z,
  output logic [COLOR_W-1:0] out_red,
  output logic [COLOR_W-1:0] out_green,
  output logic [COLOR_W-1:0] out_blue,
  output logic               is_last
);

  back_state_t        state;
  back_state_t        state_next;
  line_t              cur;
  logic [COORD_W-1:0] step;
  logic [COORD_W-1:0] quo [NUM_AXES];
  logic [COORD_W-1:0] rem [NUM_AXES];
  logic [COORD_W-1:0] quo_next [NUM_AXES];
  logic [COORD_W-1:0] rem_next [NUM_AXES];
  logic [COORD_W:0]   sum [NUM_AXES];
  logic               last_beat;

  assign last_beat = (state == S_RUN) && (step == cur.cnt);
  assign pop       = head_valid && ((state == S_IDLE) || last_beat);

  // Each step moves the numerator k*delta + count/2 by delta; at most one wrap.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      sum[a] = {1'b0, rem[a]} + {1'b0, cur.ax[a].delta};
      if (!cur.ax[a].rev) begin
        if (sum[a] >= {1'b0, cur.cnt}) begin
          rem_next[a] = COORD_W'(sum[a] - {1'b0, cur.cnt});
          quo_next[a] = quo[a] + 1'b1;
        end else begin
          rem_next[a] = sum[a][COORD_W-1:0];
          quo_next[a] = quo[a];
        end
      end else if (rem[a] >= cur.ax[a].delta) begin
        rem_next[a] = rem[a] - cur.ax[a].delta;
        quo_next[a] = quo[a];
      end else begin
        rem_next[a] = COORD_W'({1'b0, rem[a]} + {1'b0, cur.cnt} - {1'b0, cur.ax[a].delta});
        quo_next[a] = quo[a] - 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (pop) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (last_beat && !pop) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      voxel_valid <= 1'b0;
    end else begin
      state       <= state_next;
      voxel_valid <= state == S_RUN;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur  <= head;
      step <= '0;
      for (int a = 0; a < NUM_AXES; a++) begin
        quo[a] <= head.ax[a].rev ? head.ax[a].delta : '0;
        rem[a] <= head.cnt >> 1;
      end
    end else if (state == S_RUN) begin
      step <= step + 1'b1;
      for (int a = 0; a < NUM_AXES; a++) begin
        quo[a] <= quo_next[a];
        rem[a] <= rem_next[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RUN) begin
      voxel_x   <= cur.ax[0].lo + quo[0];
      voxel_y   <= cur.ax[1].lo + quo[1];
      voxel_z   <= cur.ax[2].lo + quo[2];
      out_red   <= cur.red;
      out_green <= cur.green;
      out_blue  <= cur.blue;
      is_last   <= last_beat;
    end
  end

  `VLR_ASSERT_SAME(a_step_in_range, state == S_RUN, step <= cur.cnt)
  `VLR_ASSERT_SAME(a_rem_below_count, (state == S_RUN) && (cur.cnt != '0), (rem[0] < cur.cnt) && (rem[1] < cur.cnt) && (rem[2] < cur.cnt))
  `VLR_ASSERT_NEXT(a_run_strobes, state == S_RUN, voxel_valid)
  `VLR_ASSERT_NEXT(a_results_contiguous, voxel_valid && !is_last, voxel_valid)

endmodule

`default_nettype wire

@@ design/voxel_line_rasterizer.sv @@
// Top level of the voxel line rasterizer: front end, request queue and back end.
// Depends on vlr_pkg, vlr_front, vlr_queue and vlr_back.
//
//   channel   | handshake            | payload
//   ----------+----------------------+-------------------------------------------
//   request   | start, busy          | start_x/y/z, end_x/y/z, color_red/green/blue
//   result    | voxel_valid (strobe) | voxel_x/y/z, out_red/green/blue, is_last
//
// A request gives count+1 results, one per cycle, where count is the largest axis delta.
// The back end pops the next request on the last step of the current; count+1 is 1 to 8.
// From idle, the first result passes queue, back-end state and output registers.
// busy is high while the two-entry queue is full. Synchronous reset empties the queue.
// Results cannot be held off; the strobe marks each one for one cycle.
`timescale 1ns / 1ps
`default_nettype none

module voxel_line_rasterizer import vlr_pkg::*; #(
  parameter int SIDE = SIDE_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [COORD_W-1:0] start_x,
  input  logic [COORD_W-1:0] start_y,
  input  logic [COORD_W-1:0] start_z,
  input  logic [COORD_W-1:0] end_x,
  input  logic [COORD_W-1:0] end_y,
  input  logic [COORD_W-1:0] end_z,
  input  logic [COLOR_W-1:0] color_red,
  input  logic [COLOR_W-1:0] color_green,
  input  logic [COLOR_W-1:0] color_blue,
  output logic               voxel_valid,
  output logic [COORD_W-1:0] voxel_x,
  output logic [COORD_W-1:0] voxel_y,
  output logic [COORD_W-1:0] voxel_z,
  output logic [COLOR_W-1:0] out_red,
  output logic [COLOR_W-1:0] out_green,
  output logic [COLOR_W-1:0] out_blue,
  output logic               is_last
);

  logic  push;
  line_t push_item;
  line_t head;
  logic  head_valid;
  logic  pop;

  vlr_front #(.SIDE(SIDE)) u_front (
    .start       (start),
    .busy        (busy),
    .start_x     (start_x),
    .start_y     (start_y),
    .start_z     (start_z),
    .end_x       (end_x),
    .end_y       (end_y),
    .end_z       (end_z),
    .color_red   (color_red),
    .color_green (color_green),
    .color_blue  (color_blue),
    .push        (push),
    .item        (push_item)
  );

  vlr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (busy)
  );

  vlr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (head_valid),
    .pop         (pop),
    .voxel_valid (voxel_valid),
    .voxel_x     (voxel_x),
    .voxel_y     (voxel_y),
    .voxel_z     (voxel_z),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .is_last     (is_last)
  );

endmodule

`default_nettype wire

@@ tb/voxel_line_rasterizer_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for voxel_line_rasterizer: directed and random line requests,
// with every voxel compared against the in-bench line predictor or a directed ramp.
// Depends on vlr_pkg and the voxel_line_rasterizer RTL.

module voxel_line_rasterizer_test;
  import vlr_pkg::*;

  localparam int SIDE         = SIDE_DEFAULT;
  localparam int RANDOM_LINES = 235;
  localparam int CALM_TAIL    = 40;
  localparam int STALL_LIMIT  = 200;
  localparam int DRAIN_CYCLES = 16;
  localparam int NUM_DIRECTED = 17;

  typedef struct packed {
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] sz;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
    logic [COORD_W-1:0] ez;
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
  } line_req_t;

  // A straight run of n voxels from (x0,y0,z0) moving by (dx,dy,dz) each step.
  // n of zero means the voxels come from the predictor instead.
  typedef struct packed {
    int n;
    int x0;
    int y0;
    int z0;
    int dx;
    int dy;
    int dz;
  } ramp_t;

  typedef struct packed {
    int sx;
    int sy;
    int sz;
    int ex;
    int ey;
    int ez;
    int r;
    int g;
    int b;
    ramp_t ramp;
  } dir_row_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
    logic               last;
  } voxel_t;

  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    '{0, 0, 0, 0, 0, 0,   0,   0,   0, '{1, 0, 0, 0,  0,  0,  0}},
    '{7, 7, 7, 7, 7, 7, 255, 255, 255, '{1, 7, 7, 7,  0,  0,  0}},
    '{0, 3, 5, 7, 3, 5, 255,   0,   0, '{8, 0, 3, 5,  1,  0,  0}},
    '{7, 2, 6, 0, 2, 6,   0, 255,   0, '{8, 7, 2, 6, -1,  0,  0}},
    '{4, 0, 1, 4, 7, 1,   0,   0, 255, '{8, 4, 0, 1,  0,  1,  0}},
    '{2, 6, 7, 2, 6, 0, 170,  85, 170, '{8, 2, 6, 7,  0,  0, -1}},
    '{0, 0, 0, 7, 7, 7,  85, 170,  85, '{8, 0, 0, 0,  1,  1,  1}},
    '{7, 7, 7, 0, 0, 0,   1,   2,   4, '{8, 7, 7, 7, -1, -1, -1}},
    '{7, 0, 7, 0, 7, 0, 128,  64,  32, '{8, 7, 0, 7, -1,  1, -1}},
    '{5, 5, 5, 5, 5, 4,  16,   8, 254, '{2, 5, 5, 5,  0,  0, -1}},
    '{3, 3, 3, 4, 2, 3, 127, 128, 129, '{2, 3, 3, 3,  1, -1,  0}},
    '{0, 0, 0, 7, 3, 1,  11,  22,  33, '{0, 0, 0, 0,  0,  0,  0}},
    '{0, 0, 0, 2, 1, 0,  44,  55,  66, '{0, 0, 0, 0,  0,  0,  0}},
    '{7, 1, 6, 0, 4, 2,  77,  88,  99, '{0, 0, 0, 0,  0,  0,  0}},
    '{1, 2, 3, 6, 5, 0, 200, 100,  50, '{0, 0, 0, 0,  0,  0,  0}},
    '{6, 0, 3, 3, 7, 4,  15, 240,  60, '{0, 0, 0, 0,  0,  0,  0}},
    '{2, 5, 0, 5, 1, 1, 195,  90, 165, '{0, 0, 0, 0,  0,  0,  0}}
  };

  logic clk;
  logic rst;
  logic start;
  logic busy;
  line_req_t req;
  ramp_t ramp;
  logic voxel_valid;
  logic [COORD_W-1:0] voxel_x;
  logic [COORD_W-1:0] voxel_y;
  logic [COORD_W-1:0] voxel_z;
  logic [COLOR_W-1:0] out_red;
  logic [COLOR_W-1:0] out_green;
  logic [COLOR_W-1:0] out_blue;
  logic is_last;

  voxel_t expected_voxels[$];
  int lines_taken;
  int voxels_checked;
  int line_ends;
  int mismatches;
  int stall_cycles;

  voxel_line_rasterizer #(.SIDE(SIDE)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .start_x(req.sx),
    .start_y(req.sy),
    .start_z(req.sz),
    .end_x(req.ex),
    .end_y(req.ey),
    .end_z(req.ez),
    .color_red(req.r),
    .color_green(req.g),
    .color_blue(req.b),
    .voxel_valid(voxel_valid),
    .voxel_x(voxel_x),
    .voxel_y(voxel_y),
    .voxel_z(voxel_z),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue),
    .is_last(is_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int clip_coord(input logic [COORD_W-1:0] c);
    return (int'(c) > SIDE - 1) ? SIDE - 1 : int'(c);
  endfunction

  function automatic void trace_line(input line_req_t line);
    int a[3];
    int b[3];
    int lo[3];
    int del[3];
    bit rev[3];
    int pos[3];
    int steps;
    int k;
    voxel_t v;
    a[0] = clip_coord(line.sx);
    a[1] = clip_coord(line.sy);
    a[2] = clip_coord(line.sz);
    b[0] = clip_coord(line.ex);
    b[1] = clip_coord(line.ey);
    b[2] = clip_coord(line.ez);
    steps = 0;
    for (int ax = 0; ax < 3; ax++) begin
      rev[ax] = a[ax] > b[ax];
      lo[ax] = rev[ax] ? b[ax] : a[ax];
      del[ax] = rev[ax] ? a[ax] - b[ax] : b[ax] - a[ax];
      if (del[ax] > steps) steps = del[ax];
    end
    v.r = line.r;
    v.g = line.g;
    v.b = line.b;
    v.last = 1'b0;
    for (int i = 0; i < steps; i++) begin
      for (int ax = 0; ax < 3; ax++) begin
        k = rev[ax] ? steps - i : i;
        pos[ax] = lo[ax] + (k * del[ax] + steps / 2) / steps;
      end
      v.x = COORD_W'(pos[0]);
      v.y = COORD_W'(pos[1]);
      v.z = COORD_W'(pos[2]);
      expected_voxels.push_back(v);
    end
    v.x = COORD_W'(b[0]);
    v.y = COORD_W'(b[1]);
    v.z = COORD_W'(b[2]);
    v.last = 1'b1;
    expected_voxels.push_back(v);
  endfunction

  function automatic void push_ramp(input line_req_t line, input ramp_t rp);
    voxel_t v;
    v.r = line.r;
    v.g = line.g;
    v.b = line.b;
    for (int j = 0; j < rp.n; j++) begin
      v.x = COORD_W'(rp.x0 + j * rp.dx);
      v.y = COORD_W'(rp.y0 + j * rp.dy);
      v.z = COORD_W'(rp.z0 + j * rp.dz);
      v.last = (j == rp.n - 1);
      expected_voxels.push_back(v);
    end
  endfunction

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    voxel_t want;
    if (!rst) begin
      stall_cycles++;
      if (start && !busy) begin
        if (ramp.n != 0) push_ramp(req, ramp);
        else trace_line(req);
        lines_taken++;
        stall_cycles = 0;
      end
      if (voxel_valid) begin
        stall_cycles = 0;
        if (expected_voxels.size() == 0) begin
          $error("voxel (%0d,%0d,%0d) arrived with no request outstanding",
                 voxel_x, voxel_y, voxel_z);
          mismatches++;
        end else begin
          want = expected_voxels.pop_front();
          compare_field("voxel_x", int'(want.x), int'(voxel_x));
          compare_field("voxel_y", int'(want.y), int'(voxel_y));
          compare_field("voxel_z", int'(want.z), int'(voxel_z));
          compare_field("out_red", int'(want.r), int'(out_red));
          compare_field("out_green", int'(want.g), int'(out_green));
          compare_field("out_blue", int'(want.b), int'(out_blue));
          compare_field("is_last", int'(want.last), int'(is_last));
          voxels_checked++;
          if (is_last) line_ends++;
        end
      end
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  task automatic issue(input line_req_t line, input ramp_t rp, input int gap);
    int seen;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    seen = lines_taken;
    req <= line;
    ramp <= rp;
    start <= 1'b1;
    do @(negedge clk); while (lines_taken == seen);
  endtask

  function automatic int pick_gap(input int idx, input int total);
    if (idx >= total - CALM_TAIL || $urandom_range(2) != 0) return 0;
    return $urandom_range(17, 1);
  endfunction

  initial begin
    line_req_t line;
    ramp_t no_ramp;
    int total;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    ramp = '0;
    no_ramp = '0;
    lines_taken = 0;
    voxels_checked = 0;
    line_ends = 0;
    mismatches = 0;
    stall_cycles = 0;
    total = NUM_DIRECTED + RANDOM_LINES;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      line.sx = COORD_W'(DIRECTED[i].sx);
      line.sy = COORD_W'(DIRECTED[i].sy);
      line.sz = COORD_W'(DIRECTED[i].sz);
      line.ex = COORD_W'(DIRECTED[i].ex);
      line.ey = COORD_W'(DIRECTED[i].ey);
      line.ez = COORD_W'(DIRECTED[i].ez);
      line.r = COLOR_W'(DIRECTED[i].r);
      line.g = COLOR_W'(DIRECTED[i].g);
      line.b = COLOR_W'(DIRECTED[i].b);
      issue(line, DIRECTED[i].ramp, pick_gap(i, total));
    end

    for (int i = NUM_DIRECTED; i < total; i++) begin
      line.sx = COORD_W'($urandom);
      line.sy = COORD_W'($urandom);
      line.sz = COORD_W'($urandom);
      line.r = COLOR_W'($urandom);
      line.g = COLOR_W'($urandom);
      line.b = COLOR_W'($urandom);
      if ($urandom_range(7) == 0) begin
        line.ex = line.sx;
        line.ey = line.sy;
        line.ez = line.sz;
      end else begin
        line.ex = COORD_W'($urandom);
        line.ey = COORD_W'($urandom);
        line.ez = COORD_W'($urandom);
      end
      issue(line, no_ramp, pick_gap(i, total));
    end

    start <= 1'b0;
    while (expected_voxels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Rasterized %0d line requests (%0d directed, the rest random) into %0d voxels,",
             lines_taken, NUM_DIRECTED, voxels_checked);
    $display("%0d of them line ends, with random request gaps and a back-to-back finish.",
             line_ends);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/vlr_pkg.sv
design/vlr_front.sv
design/vlr_queue.sv
design/vlr_back.sv
design/voxel_line_rasterizer.sv
tb/voxel_line_rasterizer_test.sv
